FILE: rtl/xild_pkg.sv
// shared types and constants for the x86 instruction length decoder
package xild_pkg;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 112;

  typedef enum logic [2:0] {
    PH_PREFIX,
    PH_OP2,
    PH_MODRM,
    PH_SIB,
    PH_DISP,
    PH_IMM
  } phase_e;

  typedef enum logic [1:0] {
    FLOW_PLAIN = 2'd0,
    FLOW_CALL  = 2'd1,
    FLOW_JUMP  = 2'd2,
    FLOW_RET   = 2'd3
  } flow_e;

  localparam logic [7:0] OpOpsize = 8'h66;
  localparam logic [7:0] OpRep    = 8'hF3;
  localparam logic [7:0] OpRepne  = 8'hF2;
  localparam logic [7:0] OpCall   = 8'hE8;
  localparam logic [7:0] OpJmp32  = 8'hE9;
  localparam logic [7:0] OpJmp8   = 8'hEB;
  localparam logic [7:0] OpEsc    = 8'h0F;
  localparam logic [7:0] OpMovImm = 8'hC7;
  localparam logic [7:0] OpLea    = 8'h8D;
  localparam logic [7:0] OpGrp5   = 8'hFF;
  localparam logic [7:0] OpRet    = 8'hC3;
  localparam logic [7:0] OpRetImm = 8'hC2;

  // what the opcode asks for after itself
  typedef struct packed {
    logic       done;
    logic       esc;
    logic       modrm;
    logic [3:0] imm;
    logic [2:0] rel;
    flow_e      flow;
  } op_plan_t;

  function automatic logic [3:0] imm_full(input logic rex_w, input logic f66);
    return (!rex_w && f66) ? 4'd2 : 4'd4;
  endfunction

  function automatic op_plan_t dec_primary(input logic [7:0] op, input logic rex_w,
                                           input logic f66);
    op_plan_t p;
    p = '{done: 1'b0, esc: 1'b0, modrm: 1'b0, imm: 4'd0, rel: 3'd0, flow: FLOW_PLAIN};
    priority case (1'b1)
      op == OpRet || op == 8'hCB: begin
        p.done = 1'b1;
        p.flow = FLOW_RET;
      end
      op == OpRetImm || op == 8'hCA: begin
        p.imm  = 4'd2;
        p.flow = FLOW_RET;
      end
      op == OpCall: begin
        p.rel  = 3'd4;
        p.flow = FLOW_CALL;
      end
      op == OpJmp32: begin
        p.rel  = 3'd4;
        p.flow = FLOW_JUMP;
      end
      op == OpJmp8: begin
        p.rel  = 3'd1;
        p.flow = FLOW_JUMP;
      end
      op == 8'h68: p.imm = 4'd4;
      op == 8'h6A: p.imm = 4'd1;
      op == OpEsc: p.esc = 1'b1;
      op == 8'h88 || op == 8'h89 || op == 8'h8A || op == 8'h8B || op == OpLea ||
      op == 8'h84 || op == 8'h85 || op == OpGrp5 || op == 8'hD0 || op == 8'hD1 ||
      op == 8'hD2 || op == 8'hD3 || op == 8'hF6 || op == 8'hF7:
        p.modrm = 1'b1;
      op == 8'hC6 || op == 8'h6B || op == 8'h80 || op == 8'h82 || op == 8'h83 ||
      op == 8'hC0 || op == 8'hC1: begin
        p.modrm = 1'b1;
        p.imm   = 4'd1;
      end
      op == OpMovImm || op == 8'h81: begin
        p.modrm = 1'b1;
        p.imm   = imm_full(rex_w, f66);
      end
      op == 8'h69: begin
        p.modrm = 1'b1;
        p.imm   = 4'd4;
      end
      op[7:4] == 4'h7: begin
        p.rel  = 3'd1;
        p.flow = FLOW_JUMP;
      end
      op[7:6] == 2'b00 && op[2] == 1'b0: p.modrm = 1'b1;
      op[7:6] == 2'b00 && op[2:0] == 3'd4: p.imm = 4'd1;
      op[7:6] == 2'b00 && op[2:0] == 3'd5: p.imm = imm_full(rex_w, f66);
      op[7:6] == 2'b00: p.done = 1'b1;
      op[7:3] == 5'b10110: p.imm = 4'd1;
      op[7:3] == 5'b10111: p.imm = rex_w ? 4'd8 : imm_full(rex_w, f66);
      default: p.done = 1'b1;
    endcase
    return p;
  endfunction

  function automatic op_plan_t dec_second(input logic [7:0] op2);
    op_plan_t p;
    p = '{done: 1'b0, esc: 1'b0, modrm: 1'b0, imm: 4'd0, rel: 3'd0, flow: FLOW_PLAIN};
    priority case (1'b1)
      op2 == 8'h1F || op2 == 8'h1E || op2[7:4] == 4'h4 || op2 == 8'hAF ||
      op2 == 8'hB6 || op2 == 8'hBE || op2 == 8'hB7 || op2 == 8'hBF:
        p.modrm = 1'b1;
      op2[7:4] == 4'h8: begin
        p.rel  = 3'd4;
        p.flow = FLOW_JUMP;
      end
      default: p.done = 1'b1;
    endcase
    return p;
  endfunction

  function automatic logic [3:0] disp_size(input logic [1:0] md, input logic [2:0] base);
    logic [3:0] n;
    unique case (md)
      2'd1:    n = 4'd1;
      2'd2:    n = 4'd4;
      default: n = (base == 3'd5) ? 4'd4 : 4'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/x86_instruction_length_decoder.sv
// byte-serial x86-64 instruction length decoder
//
// channel  dir  tdata (low bit up)                                      tlast
// s_axis   in   code_byte[7:0] insn_addr[71:8]                          last_byte
// m_axis   out  see m_axis_tdata_o                                      -
//
// one code byte per cycle; a result leaves a register in the cycle after the byte
// that completes an instruction or has tlast set. the byte parser state and the
// 64-bit target adder sit between the input handshake and the result register.
// reset returns the parser to the prefix phase with all fields cleared.
// a stalled result holds input only when the result register is still full.
module x86_instruction_length_decoder
  import xild_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [InDataW-1:0]  s_axis_tdata_i,  // code_byte, insn_addr
  input  logic                s_axis_tlast_i,  // last_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // insn_length, flow_class, has_target, branch_target, primary_opcode, escaped,
  // second_opcode, has_modrm, modrm_value, rex_bits, operand_width, truncated, pad
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  cnt_q, cnt_d;
  logic [63:0] start_q, start_d;
  logic [3:0]  rex_q, rex_d;
  logic        f66_q, f66_d;
  logic [7:0]  op1_q, op1_d, op2_q, op2_d, modrm_q, modrm_d;
  logic [3:0]  left_q, left_d, pend_q, pend_d;
  logic [31:0] disp_q, disp_d;
  logic [2:0]  rel_q, rel_d;
  logic        seen_q, seen_d;
  flow_e       flow_q, flow_d;

  logic                out_valid_q;
  logic [OutDataW-1:0] out_data_q;

  logic        accept, done, trunc;
  logic [7:0]  b;
  op_plan_t    pl;
  logic [3:0]  dn, left_dec;
  logic [1:0]  idx;
  logic [7:0]  o_op1, o_op2, o_modrm;
  logic        o_seen;
  logic [63:0] rel_ext, target;
  logic [1:0]  opw;

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign b               = s_axis_tdata_i[7:0];
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  always_comb begin
    phase_d  = phase_q;
    cnt_d    = (cnt_q == 8'd255) ? cnt_q : cnt_q + 8'd1;
    start_d  = (phase_q == PH_PREFIX && cnt_q == 8'd0) ? s_axis_tdata_i[71:8] : start_q;
    rex_d    = rex_q;
    f66_d    = f66_q;
    op1_d    = op1_q;
    op2_d    = op2_q;
    modrm_d  = modrm_q;
    left_d   = left_q;
    pend_d   = pend_q;
    disp_d   = disp_q;
    rel_d    = rel_q;
    seen_d   = seen_q;
    flow_d   = flow_q;
    done     = 1'b0;
    pl       = dec_primary(b, rex_q[3], f66_q);
    dn       = 4'd0;
    left_dec = (left_q != 4'd0) ? left_q - 4'd1 : 4'd0;
    idx      = 2'(rel_q - 3'(left_q));
    unique case (phase_q)
      PH_PREFIX: begin
        priority case (1'b1)
          b == OpOpsize: f66_d = 1'b1;
          b == OpRep || b == OpRepne: ;
          b == 8'h26 || b == 8'h2E || b == 8'h36 || b == 8'h3E || b == 8'h64 ||
          b == 8'h65: ;
          b[7:4] == 4'h4: rex_d = b[3:0];
          default: begin
            op1_d  = b;
            flow_d = pl.flow;
            rel_d  = pl.rel;
            pend_d = (pl.rel != 3'd0) ? {1'b0, pl.rel} : pl.imm;
            priority case (1'b1)
              pl.done:  done = 1'b1;
              pl.esc:   phase_d = PH_OP2;
              pl.modrm: phase_d = PH_MODRM;
              pend_d == 4'd0: done = 1'b1;
              default: begin
                phase_d = PH_IMM;
                left_d  = pend_d;
              end
            endcase
          end
        endcase
      end
      PH_OP2: begin
        pl     = dec_second(b);
        op2_d  = b;
        flow_d = pl.flow;
        rel_d  = pl.rel;
        pend_d = (pl.rel != 3'd0) ? {1'b0, pl.rel} : pl.imm;
        priority case (1'b1)
          pl.done:  done = 1'b1;
          pl.modrm: phase_d = PH_MODRM;
          default: begin
            phase_d = PH_IMM;
            left_d  = pend_d;
          end
        endcase
      end
      PH_MODRM, PH_SIB: begin
        if (phase_q == PH_MODRM) begin
          modrm_d = b;
          seen_d  = 1'b1;
          if (op1_q == 8'hF6 && b[5:3] == 3'd0) pend_d = 4'd1;
          if (op1_q == 8'hF7 && b[5:3] == 3'd0) pend_d = imm_full(rex_q[3], f66_q);
          if (op1_q == OpGrp5 && b[5:3] == 3'd2) flow_d = FLOW_CALL;
          if (op1_q == OpGrp5 && b[5:3] == 3'd4) flow_d = FLOW_JUMP;
          dn = (b[7:6] == 2'd3) ? 4'd0 : disp_size(b[7:6], b[2:0]);
        end else begin
          dn = disp_size(modrm_q[7:6], b[2:0]);
        end
        priority case (1'b1)
          phase_q == PH_MODRM && b[7:6] != 2'd3 && b[2:0] == 3'd4: phase_d = PH_SIB;
          dn != 4'd0: begin
            phase_d = PH_DISP;
            left_d  = dn;
          end
          pend_d == 4'd0: done = 1'b1;
          default: begin
            phase_d = PH_IMM;
            left_d  = pend_d;
          end
        endcase
      end
      PH_DISP: begin
        left_d = left_dec;
        if (left_dec == 4'd0) begin
          if (pend_q == 4'd0) begin
            done = 1'b1;
          end else begin
            phase_d = PH_IMM;
            left_d  = pend_q;
          end
        end
      end
      default: begin
        if (rel_q != 3'd0 && left_q != 4'd0 && {1'b0, left_q} <= {2'b0, rel_q})
          disp_d = disp_q | (32'(b) << {idx, 3'b000});
        left_d = left_dec;
        done   = (left_dec == 4'd0);
      end
    endcase
  end

  // missing bytes read as zero: only the opcode and modrm fields can still change
  always_comb begin
    trunc   = s_axis_tlast_i && !done;
    o_op1   = op1_d;
    o_op2   = op2_d;
    o_modrm = modrm_d;
    o_seen  = seen_d;
    if (trunc) begin
      unique case (phase_d)
        PH_PREFIX: begin
          o_op1   = 8'h00;
          o_seen  = 1'b1;
          o_modrm = 8'h00;
        end
        PH_OP2: o_op2 = 8'h00;
        PH_MODRM: begin
          o_seen  = 1'b1;
          o_modrm = 8'h00;
        end
        default: ;
      endcase
    end
    rel_ext = (rel_d == 3'd1) ? {{56{disp_d[7]}}, disp_d[7:0]} : {{32{disp_d[31]}}, disp_d};
    target  = (rel_d != 3'd0) ? start_d + {56'd0, cnt_d} + rel_ext : 64'd0;
    opw     = rex_d[3] ? 2'd2 : (f66_d ? 2'd0 : 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_PREFIX;
      cnt_q   <= 8'd0;
      start_q <= 64'd0;
      rex_q   <= 4'd0;
      f66_q   <= 1'b0;
      op1_q   <= 8'd0;
      op2_q   <= 8'd0;
      modrm_q <= 8'd0;
      left_q  <= 4'd0;
      pend_q  <= 4'd0;
      disp_q  <= 32'd0;
      rel_q   <= 3'd0;
      seen_q  <= 1'b0;
      flow_q  <= FLOW_PLAIN;
      out_valid_q <= 1'b0;
    end else begin
      if (accept && (done || s_axis_tlast_i)) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      if (accept) begin
        start_q <= start_d;
        if (done || s_axis_tlast_i) begin
          phase_q <= PH_PREFIX;
          cnt_q   <= 8'd0;
          rex_q   <= 4'd0;
          f66_q   <= 1'b0;
          op1_q   <= 8'd0;
          op2_q   <= 8'd0;
          modrm_q <= 8'd0;
          left_q  <= 4'd0;
          pend_q  <= 4'd0;
          disp_q  <= 32'd0;
          rel_q   <= 3'd0;
          seen_q  <= 1'b0;
          flow_q  <= FLOW_PLAIN;
        end else begin
          phase_q <= phase_d;
          cnt_q   <= cnt_d;
          rex_q   <= rex_d;
          f66_q   <= f66_d;
          op1_q   <= op1_d;
          op2_q   <= op2_d;
          modrm_q <= modrm_d;
          left_q  <= left_d;
          pend_q  <= pend_d;
          disp_q  <= disp_d;
          rel_q   <= rel_d;
          seen_q  <= seen_d;
          flow_q  <= flow_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (done || s_axis_tlast_i)) begin
      out_data_q <= {4'd0, trunc, opw, rex_d, o_modrm, o_seen, o_op2,
                     (o_op1 == OpEsc), o_op1, target, (rel_d != 3'd0), flow_d, cnt_d};
    end
  end

endmodule
